FILE: rtl/asrs_pkg.sv
// Shared constants and instruction decode helpers for the ADRP/store reference scanner.
// No dependencies; imported by the scanner core and its checker.
`timescale 1ns / 1ps

package asrs_pkg;

	localparam int ADDR_W   = 64;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 62;
	localparam int NUM_REGS = 32;
	localparam int REG_W    = 5;

	// default pairing window in words
	localparam int DEF_WINDOW_WORDS = 15;

	// opcode masks and match patterns
	localparam logic [WORD_W-1:0] ADRP_MASK  = 32'h9F00_0000;
	localparam logic [WORD_W-1:0] ADRP_MATCH = 32'h9000_0000;
	localparam logic [WORD_W-1:0] STR_MASK   = 32'h3F40_0000;
	localparam logic [WORD_W-1:0] STR_MATCH  = 32'h3900_0000;
	localparam logic [WORD_W-1:0] ADD_MASK   = 32'h7F00_0000;
	localparam logic [WORD_W-1:0] ADD_MATCH  = 32'h1100_0000;
	localparam logic [WORD_W-1:0] LDR_MASK   = 32'hFFC0_0000;
	localparam logic [WORD_W-1:0] LDR_MATCH  = 32'hF940_0000;

	// decoded view of one instruction word
	typedef struct packed {
		logic             is_adrp;
		logic             is_str;
		logic             kills_rd;
		logic [REG_W-1:0] rd;
		logic [REG_W-1:0] rn;
	} insn_dec_t;

	function automatic insn_dec_t decode(input logic [WORD_W-1:0] w);
		insn_dec_t d;
		d.is_adrp  = (w & ADRP_MASK) == ADRP_MATCH;
		d.is_str   = (w & STR_MASK) == STR_MATCH;
		d.kills_rd = d.is_adrp || ((w & ADD_MASK) == ADD_MATCH) ||
			((w & LDR_MASK) == LDR_MATCH);
		d.rd       = w[4:0];
		d.rn       = w[9:5];
		return d;
	endfunction

	// page-relative displacement of an ADRP, sign-extended and shifted by 12
	function automatic logic [ADDR_W-1:0] adrp_disp(input logic [WORD_W-1:0] w);
		logic [20:0] imm;
		imm = {w[23:5], w[30:29]};
		return {{(ADDR_W-33){imm[20]}}, imm, 12'h000};
	endfunction

	// store offset: imm12 scaled by the access size
	function automatic logic [ADDR_W-1:0] store_off(input logic [WORD_W-1:0] w);
		logic [ADDR_W-1:0] imm;
		imm = {{(ADDR_W-12){1'b0}}, w[21:10]};
		return imm << w[31:30];
	endfunction

endpackage

FILE: rtl/adrp_store_ref_scanner_core.sv
// ADRP/store reference scanner top level: input register, pending-page table, result register.
// Depends on asrs_pkg.
`timescale 1ns / 1ps

// Takes one instruction word per cycle while in_stall is low. After the input register, the result
// register gives a store's data address if it pairs with an ADRP seen within the last WINDOW_WORDS
// words. The word address (base_address plus four times the position) is formed as the word is
// registered; the input-register stage reads the 32-entry pending-page table at the store's base
// register and adds the scaled offset, and the 64-bit adds set the cycle time. Pending entries
// age with a small per-entry counter, so no position compare spans the table. in_stall rises only
// while a result waits in the output register under out_stall. base_address is to be written via
// cfg_wr_en/cfg_wr_data only while no item is in flight; the block itself does not enforce this.
module adrp_store_ref_scanner_core #(
	parameter int WINDOW_WORDS = asrs_pkg::DEF_WINDOW_WORDS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [asrs_pkg::ADDR_W-1:0]  cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [asrs_pkg::WORD_W-1:0]  insn_word,
	input  logic                         last_word,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [asrs_pkg::ADDR_W-1:0]  ref_address
);
	import asrs_pkg::*;

	localparam int AGE_W = $clog2(WINDOW_WORDS + 1);

	logic [ADDR_W-1:0]  base_q;
	logic [POS_W-1:0]   pos_q;

	logic               valid_s1;
	logic [WORD_W-1:0]  insn_s1;
	logic               last_s1;
	logic [ADDR_W-1:0]  addr_s1;

	logic [NUM_REGS-1:0] pend_valid_q;
	logic [AGE_W-1:0]    pend_age_q  [NUM_REGS];
	logic [ADDR_W-1:0]   pend_page_q [NUM_REGS];

	logic                out_valid_q;
	logic [ADDR_W-1:0]   ref_address_q;

	logic                in_acc;
	logic                fire_s1;
	insn_dec_t           dec;
	logic                hit;
	logic [ADDR_W-1:0]   page_new;
	logic [ADDR_W-1:0]   ref_new;
	logic [NUM_REGS-1:0] valid_nxt;

	// handshake
	assign fire_s1   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign ref_address = ref_address_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	// position count and input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				pos_q    <= last_word ? '0 : pos_q + POS_W'(1);
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			insn_s1 <= insn_word;
			last_s1 <= last_word;
			addr_s1 <= base_q + {pos_q, 2'b00};
		end
	end

	// decode, table lookup and address forming
	always_comb begin
		dec      = decode(insn_s1);
		hit      = dec.is_str && pend_valid_q[dec.rn];
		ref_new  = pend_page_q[dec.rn] + store_off(insn_s1);
		page_new = {addr_s1[ADDR_W-1:12], 12'h000} + adrp_disp(insn_s1);
	end

	// next valid bits: consume on store, end on add/ldr/adrp, record adrp, age out, clear on last word
	always_comb begin
		for (int r = 0; r < NUM_REGS; r++) begin
			valid_nxt[r] = pend_valid_q[r];
			if (hit && (dec.rn == REG_W'(r))) begin
				valid_nxt[r] = 1'b0;
			end
			if (dec.kills_rd && (dec.rd == REG_W'(r))) begin
				valid_nxt[r] = 1'b0;
			end
			if (dec.is_adrp && (dec.rd == REG_W'(r))) begin
				valid_nxt[r] = 1'b1;
			end else if (pend_age_q[r] == AGE_W'(WINDOW_WORDS)) begin
				// entry would be older than the window at the next item
				valid_nxt[r] = 1'b0;
			end
			if (last_s1) begin
				valid_nxt[r] = 1'b0;
			end
		end
	end

	// pending table valid bits and ages; age holds the distance seen by the next item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= '0;
		end else if (fire_s1) begin
			pend_valid_q <= valid_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				if (dec.is_adrp && (dec.rd == REG_W'(r))) begin
					pend_age_q[r] <= AGE_W'(1);
				end else if (pend_age_q[r] != AGE_W'(WINDOW_WORDS)) begin
					pend_age_q[r] <= pend_age_q[r] + AGE_W'(1);
				end
			end
			if (dec.is_adrp) begin
				pend_page_q[dec.rd] <= page_new;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= hit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && hit) begin
			ref_address_q <= ref_new;
		end
	end

endmodule

FILE: rtl/asrs_checker.sv
// Port-level checks for the ADRP/store reference scanner, bound to its top level.
// Depends on asrs_pkg and adrp_store_ref_scanner_core.
`timescale 1ns / 1ps

module asrs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [asrs_pkg::ADDR_W-1:0]  ref_address
);
	import asrs_pkg::*;

	// a stalled result item stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ref_address))
		else $error("result item changed under stall");

	// input back-pressure only comes from a blocked result
	a_stall_src: assert property (@(posedge clk)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// nothing is offered in the cycle after a reset edge
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("activity right after reset");

	// the input is never stalled while the result register is empty
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("stall with empty result register");

endmodule

bind adrp_store_ref_scanner_core asrs_checker u_asrs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.ref_address (ref_address)
);

FILE: tb/adrp_store_ref_scanner_core_test.sv
// Self-checking testbench for adrp_store_ref_scanner_core: drives instruction words and
// compares every store data address against an in-bench prediction of the pairing logic.
// Depends on asrs_pkg and the scanner core RTL.
`timescale 1ns / 1ps

module adrp_store_ref_scanner_core_test;

	import asrs_pkg::*;

	localparam logic [POS_W-1:0]  WINDOW     = POS_W'(DEF_WINDOW_WORDS);
	localparam logic [WORD_W-1:0] NOP_WORD   = 32'hD503_201F;
	localparam int                SETTLE_CYC = 6;
	localparam logic [20:0]       PAGE_MAX   = 21'h0F_FFFF;
	localparam logic [20:0]       PAGE_MIN   = 21'h10_0000;
	localparam logic [11:0]       OFF_MAX    = 12'hFFF;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [ADDR_W-1:0]  cfg_wr_data = '0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic [WORD_W-1:0]  insn_word   = '0;
	logic               last_word   = 1'b0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic [ADDR_W-1:0]  ref_address;

	// bench state
	bit                 idle_on = 1'b1;
	int                 words_sent;
	int                 refs_seen;
	int                 bad_refs;
	int                 stall_left;
	logic [ADDR_W-1:0]  expected_refs[$];

	// predicted scanner state
	logic [ADDR_W-1:0]  base_now;
	logic               pend_live[NUM_REGS];
	logic [ADDR_W-1:0]  pend_page[NUM_REGS];
	logic [POS_W-1:0]   pend_pos[NUM_REGS];
	logic [POS_W-1:0]   word_pos;

	adrp_store_ref_scanner_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.insn_word   (insn_word),
		.last_word   (last_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ref_address (ref_address)
	);

	always #5 clk = ~clk;

	// run limit
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// clear pending table and position, as at reset or after a last word
	task automatic clear_pending();
		for (int r = 0; r < NUM_REGS; r++)
			pend_live[r] = 1'b0;
		word_pos = '0;
	endtask

	// predict the effect of one accepted word, queue any store address it yields
	task automatic scan_word(input logic [WORD_W-1:0] w, input logic last);
		logic [ADDR_W-1:0] pc;
		logic [20:0]       imm21;
		logic [REG_W-1:0]  rd;
		logic [REG_W-1:0]  rn;
		logic [POS_W-1:0]  age;
		logic              adrp;
		logic              str;
		logic              ends_rd;
		pc      = base_now + {word_pos, 2'b00};
		rd      = w[4:0];
		rn      = w[9:5];
		adrp    = (w & ADRP_MASK) == ADRP_MATCH;
		str     = (w & STR_MASK) == STR_MATCH;
		ends_rd = adrp || ((w & ADD_MASK) == ADD_MATCH) || ((w & LDR_MASK) == LDR_MATCH);
		// age out entries older than the window
		for (int r = 0; r < NUM_REGS; r++) begin
			if (pend_live[r]) begin
				age = word_pos - pend_pos[r];
				if (age > WINDOW)
					pend_live[r] = 1'b0;
			end
		end
		// first matching store consumes the entry
		if (str && pend_live[rn]) begin
			expected_refs.push_back(pend_page[rn] + ({52'd0, w[21:10]} << w[31:30]));
			pend_live[rn] = 1'b0;
		end
		if (ends_rd)
			pend_live[rd] = 1'b0;
		if (adrp) begin
			imm21         = {w[23:5], w[30:29]};
			pend_live[rd] = 1'b1;
			pend_page[rd] = {pc[63:12], 12'd0} + {{31{imm21[20]}}, imm21, 12'd0};
			pend_pos[rd]  = word_pos;
		end
		word_pos = word_pos + POS_W'(1);
		if (last)
			clear_pending();
	endtask

	// instruction encoders; the store, add and ldr ones fill unused fields at random
	function automatic logic [WORD_W-1:0] adrp_word(input logic [4:0] rd, input logic [20:0] imm);
		return {1'b1, imm[1:0], 5'b10000, imm[20:2], rd};
	endfunction

	function automatic logic [WORD_W-1:0] str_word(input logic [1:0] size, input logic [11:0] off,
			input logic [4:0] rn);
		logic [31:0] r;
		r = $urandom;
		return {size, 6'b111001, r[23], 1'b0, off, rn, r[4:0]};
	endfunction

	function automatic logic [WORD_W-1:0] add_word(input logic [4:0] rd);
		logic [31:0] r;
		r = $urandom;
		return {r[31], 7'b0010001, r[23:5], rd};
	endfunction

	function automatic logic [WORD_W-1:0] ldr_word(input logic [4:0] rd);
		logic [31:0] r;
		r = $urandom;
		return {10'b1111100101, r[21:5], rd};
	endfunction

	// send one item, with an optional random gap in front
	task automatic send_word(input logic [WORD_W-1:0] w, input logic last = 1'b0);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		insn_word <= w;
		last_word <= last;
		do
			@(posedge clk);
		while (in_stall);
		words_sent++;
		scan_word(w, last);
	endtask

	// stop sending and wait until every predicted address is back
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_refs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_base(input logic [ADDR_W-1:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		base_now = v;
	endtask

	// result checker and random output stall
	always @(posedge clk) begin
		logic [ADDR_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_refs.size() == 0) begin
				$display("%0t: unexpected ref_address, expected none, actual %h",
					$time, ref_address);
				bad_refs++;
			end else begin
				want = expected_refs.pop_front();
				refs_seen++;
				if (ref_address !== want) begin
					$display("%0t: ref_address mismatch, expected %h, actual %h",
						$time, want, ref_address);
					bad_refs++;
				end
			end
		end
		if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 6) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 9);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// every store size, offset and page extremes, register 31
	task automatic test_store_sizes();
		send_word(adrp_word(5'd1, PAGE_MAX));
		send_word(str_word(2'd0, OFF_MAX, 5'd1));
		send_word(adrp_word(5'd1, PAGE_MIN));
		send_word(str_word(2'd1, OFF_MAX, 5'd1));
		send_word(adrp_word(5'd31, 21'h1F_FFFF));
		send_word(str_word(2'd2, 12'd0, 5'd31));
		send_word(adrp_word(5'd2, 21'd0));
		send_word(str_word(2'd3, OFF_MAX, 5'd2));
	endtask

	// entries ended by add, ldr, a new adrp, and by being consumed
	task automatic test_entry_ending();
		send_word(adrp_word(5'd3, 21'h00_0123));
		send_word(add_word(5'd3));
		send_word(str_word(2'd3, 12'd8, 5'd3));
		send_word(adrp_word(5'd4, 21'h00_0456));
		send_word(ldr_word(5'd4));
		send_word(str_word(2'd2, 12'd4, 5'd4));
		send_word(adrp_word(5'd5, 21'h00_0001));
		send_word(adrp_word(5'd5, 21'h1F_0000));
		send_word(str_word(2'd1, 12'd2, 5'd5));
		send_word(str_word(2'd1, 12'd2, 5'd5));
	endtask

	// store at the last word of the window pairs, one word later it does not
	task automatic test_window_edge();
		send_word(adrp_word(5'd6, 21'h00_0010));
		send_word(adrp_word(5'd7, 21'h00_0020));
		repeat (14) send_word(NOP_WORD);
		send_word(str_word(2'd3, 12'd1, 5'd7));
		send_word(str_word(2'd3, 12'd1, 5'd6));
	endtask

	// last word clears pending entries but its own store still pairs
	task automatic test_last_word();
		send_word(adrp_word(5'd8, 21'h00_0777), 1'b1);
		send_word(str_word(2'd0, 12'd3, 5'd8));
		send_word(adrp_word(5'd9, 21'h00_0002));
		send_word(str_word(2'd2, 12'd5, 5'd9), 1'b1);
	endtask

	// address arithmetic wraps at the top of the address space
	task automatic test_address_wrap();
		set_base('1);
		send_word(adrp_word(5'd10, PAGE_MAX));
		send_word(str_word(2'd3, OFF_MAX, 5'd10));
		send_word(adrp_word(5'd0, PAGE_MIN), 1'b1);
		send_word(adrp_word(5'd0, PAGE_MIN));
		send_word(str_word(2'd0, 12'd0, 5'd0));
	endtask

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 4) == 0) ? 5'd31 : 5'($urandom_range(0, 31));
	endfunction

	// mostly adrp ... store sequences with random filler, some pure noise
	task automatic test_random_mix(input int count);
		int          stop_at;
		logic [4:0]  reg_no;
		logic [31:0] w;
		int          pick;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			if ($urandom_range(0, 4) != 0) begin
				reg_no = pick_reg();
				send_word(adrp_word(reg_no, 21'($urandom)), $urandom_range(0, 60) == 0);
				repeat ($urandom_range(0, 18)) begin
					pick = $urandom_range(0, 19);
					case (pick)
						0:       w = add_word(reg_no);
						1:       w = ldr_word(reg_no);
						2:       w = adrp_word(reg_no, 21'($urandom));
						3, 4:    w = adrp_word(pick_reg(), 21'($urandom));
						5, 6:    w = str_word(2'($urandom), 12'($urandom), pick_reg());
						7:       w = add_word(pick_reg());
						8:       w = ldr_word(pick_reg());
						9, 10:   w = $urandom;
						default: w = NOP_WORD;
					endcase
					send_word(w, $urandom_range(0, 80) == 0);
				end
				if ($urandom_range(0, 7) == 0)
					reg_no = pick_reg();
				send_word(str_word(2'($urandom), 12'($urandom), reg_no),
					$urandom_range(0, 40) == 0);
			end else begin
				send_word($urandom, $urandom_range(0, 15) == 0);
			end
		end
	endtask

	// test sequence
	initial begin
		base_now = '0;
		clear_pending();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_store_sizes();
		test_entry_ending();
		test_window_edge();
		test_last_word();
		test_address_wrap();

		set_base({$urandom, $urandom});
		test_random_mix(150);
		drain();
		test_random_mix(150);
		set_base('0);
		test_random_mix(300);
		set_base(64'hFFFF_FFFF_FFFF_F000);
		test_random_mix(300);
		// last part runs with no idling on either side
		set_base({$urandom, $urandom});
		idle_on = 1'b0;
		test_random_mix(350);
		drain();

		$display("covered %0d instruction words and %0d paired store addresses", words_sent,
			refs_seen);
		$display("bases: reset value, all ones, page-aligned top, random; window and wrap cases");
		if (bad_refs == 0 && expected_refs.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
